// ===== hdl/vptw_pkg.sv =====
// ----------------------------------------------------------------------------
// vptw_pkg
// Shared operation codes, sizes and the saturation helper for the vertex
// projection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vptw_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_MODEL   = 2'd0,
    OP_PROJ    = 2'd1,
    OP_PROJECT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } reg_idx_t;

  localparam int ACC_W  = 66;
  localparam int MEM_DEPTH = 32;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -ACC_W'(64'sh0000_0000_8000_0000);
    if (v > hi) return 32'h7FFF_FFFF;
    else if (v < lo) return 32'h8000_0000;
    else return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vertex_project_to_window_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_project_to_window_unit
// Holds a model and a projection matrix in one synchronous memory and maps an
// object-space point to window coordinates with one shared multiplier for the
// matrix terms and a bit-serial divider.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   command  | start / busy            | op, element_index, element_value,
//            |                         | point_x, point_y, point_z
//   result   | done (one-cycle strobe) | window_x, window_y, window_depth,
//            |                         | projected_ok
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a matrix write does not raise busy
// a projection runs the two matrix passes (read, multiply, accumulate per term
// on the shared multiplier), then the three divisions
// a zero clip w ends the item right after the matrix passes
// rst is synchronous; matrix entries read as zero until written
// the receiver cannot stall; results leave on done for one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_project_to_window_unit
  import vptw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  element_index,
  input  wire logic [31:0] element_value,
  input  wire logic [31:0] point_x,
  input  wire logic [31:0] point_y,
  input  wire logic [31:0] point_z,
  output logic             done,
  output logic [31:0]      window_x,
  output logic [31:0]      window_y,
  output logic [31:0]      window_depth,
  output logic             projected_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int N  = 32 + FRAC_BITS;
  localparam int CW = $clog2(N);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_ACC, S_DIV, S_FIN
  } state_t;

  state_t state;

  // viewport registers
  logic [15:0] vp_org_x;
  logic [15:0] vp_org_y;
  logic [14:0] vp_w;
  logic [14:0] vp_h;

  // matrix memory: model at 0..15, projection at 16..31
  logic [31:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld;
  logic [31:0] rdata;
  logic        rvld;
  logic [4:0]  raddr;
  logic        wr_en;

  // sequencer
  logic        pass;
  logic [1:0]  row;
  logic [1:0]  k;
  logic [31:0] vec [4];
  logic [31:0] res [3];
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic [31:0] acc_sat;
  logic [31:0] clip_w;

  // divider
  logic [N-1:0]  num;
  logic [32:0]   rem;
  logic [31:0]   den;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [1:0]    axis;
  logic [32:0]   trial;
  logic          qbit;

  logic [31:0] fin_val;
  logic [31:0] div_c;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = accept && (op == OP_MODEL || op == OP_PROJ);
  assign raddr     = {pass, k, row};

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_org_x <= '0;
      vp_org_y <= '0;
      vp_w     <= '0;
      vp_h     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: vp_org_x <= cfg_data;
        REG_ORIGIN_Y: vp_org_y <= cfg_data;
        REG_WIDTH:    vp_w     <= cfg_data[14:0];
        REG_HEIGHT:   vp_h     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // matrix memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[{op[0], element_index}] <= element_value;
    rdata <= mem[raddr];
  end

  // entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rvld    <= 1'b0;
    end else begin
      if (wr_en) mem_vld[{op[0], element_index}] <= 1'b1;
      rvld <= mem_vld[raddr];
    end
  end

  // accumulate one floored product
  always_comb begin
    logic signed [63:0] term;
    term     = prod >>> FRAC_BITS;
    acc_next = acc + {{(ACC_W-64){term[63]}}, term};
    acc_sat  = sat32(acc_next);
  end

  // restoring divider step
  always_comb begin
    trial = {rem[31:0], num[N-1]};
    qbit  = (trial >= {1'b0, den});
  end

  // divider operand for the next axis
  always_comb begin
    unique case (axis)
      2'd0:    div_c = res[1];
      2'd1:    div_c = res[2];
      default: div_c = res[0];
    endcase
  end

  // map quotient to window coordinate
  always_comb begin
    logic signed [N:0]       ndc;
    logic signed [63:0]      t64;
    logic signed [48:0]      tc;
    logic signed [15:0]      sz;
    logic signed [15:0]      org;
    logic signed [64:0]      sp;
    logic signed [ACC_W-1:0] wide;
    ndc = neg ? -$signed({1'b0, num}) : $signed({1'b0, num});
    t64 = ($signed({{(63-N){ndc[N]}}, ndc}) + (64'sd1 <<< FRAC_BITS)) >>> 1;
    if (t64 > (64'sd1 <<< 47)) tc = 49'sd1 <<< 47;
    else if (t64 < -(64'sd1 <<< 47)) tc = -(49'sd1 <<< 47);
    else tc = t64[48:0];
    sz   = (axis == 2'd0) ? $signed({1'b0, vp_w}) : $signed({1'b0, vp_h});
    org  = (axis == 2'd0) ? $signed(vp_org_x) : $signed(vp_org_y);
    sp   = tc * sz;
    wide = {sp[64], sp} + ({{(ACC_W-16){org[15]}}, org} <<< FRAC_BITS);
    if (axis == 2'd2) fin_val = sat32({{(ACC_W-64){t64[63]}}, t64});
    else fin_val = sat32(wide);
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      projected_ok <= 1'b0;
      pass         <= 1'b0;
      row          <= '0;
      k            <= '0;
      axis         <= '0;
      cnt          <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && op == OP_PROJECT) begin
            vec[0] <= point_x;
            vec[1] <= point_y;
            vec[2] <= point_z;
            vec[3] <= 32'(64'd1 << FRAC_BITS);
            pass   <= 1'b0;
            row    <= '0;
            k      <= '0;
            acc    <= '0;
            state  <= S_READ;
          end
        end
        S_READ: state <= S_MUL;
        S_MUL: begin
          prod  <= $signed(vec[k]) * $signed(rvld ? rdata : 32'd0);
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_READ;
          if (k == 2'd3) begin
            k   <= '0;
            acc <= '0;
            if (row != 2'd3) begin
              res[row] <= acc_sat;
              row      <= row + 2'd1;
            end else if (!pass) begin
              vec[0] <= res[0];
              vec[1] <= res[1];
              vec[2] <= res[2];
              vec[3] <= acc_sat;
              pass   <= 1'b1;
              row    <= '0;
            end else if (acc_sat == 32'd0) begin
              window_x     <= '0;
              window_y     <= '0;
              window_depth <= '0;
              projected_ok <= 1'b0;
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              clip_w <= acc_sat;
              den    <= acc_sat[31] ? -acc_sat : acc_sat;
              num    <= {(res[0][31] ? -res[0] : res[0]), {FRAC_BITS{1'b0}}};
              neg    <= res[0][31] ^ acc_sat[31];
              rem    <= '0;
              cnt    <= CW'(N - 1);
              axis   <= 2'd0;
              state  <= S_DIV;
            end
          end else begin
            acc <= acc_next;
            k   <= k + 2'd1;
          end
        end
        S_DIV: begin
          rem <= qbit ? (trial - {1'b0, den}) : trial;
          num <= {num[N-2:0], qbit};
          cnt <= cnt - CW'(1);
          if (cnt == '0) state <= S_FIN;
        end
        S_FIN: begin
          unique case (axis)
            2'd0:    window_x     <= fin_val;
            2'd1:    window_y     <= fin_val;
            default: window_depth <= fin_val;
          endcase
          if (axis == 2'd2) begin
            projected_ok <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            num   <= {(div_c[31] ? -div_c : div_c), {FRAC_BITS{1'b0}}};
            neg   <= div_c[31] ^ clip_w[31];
            rem   <= '0;
            cnt   <= CW'(N - 1);
            axis  <= axis + 2'd1;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result strobe only ends a running projection
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running projection");

  // a failed projection reports zero coordinates
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !projected_ok) |-> (window_x == 32'd0 && window_y == 32'd0 &&
                                 window_depth == 32'd0))
    else $error("failed projection with nonzero coordinates");

  // a project command starts the sequencer
  a_project_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_PROJECT) |=> busy)
    else $error("project command did not start");

  // matrix writes never disturb a running projection
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("matrix write while busy");

endmodule

`default_nettype wire
